// ===== sv/assert_macros.svh =====
// Assertion helpers for lattice_dislocation_walk_unit.sv, the RTL file that includes them.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ldw: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ldw: next-cycle check failed");

`endif

// ===== sv/ldw_pkg.sv =====
package ldw_pkg;

    // Default sizes
    localparam int GRID_SIDE_DEF   = 256;
    localparam int MAX_ENTRIES_DEF = 1024;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 10;
    localparam int COORD8_W = 8;
    localparam int DIR_W    = 2;
    localparam int ROUND_W  = 32;
    localparam int GSIZE_W  = 9;
    localparam int CNT_W    = 11;
    localparam int CELL_W   = 2;

    // Signed coordinate width: holds -1 .. 256
    localparam int COORD_W  = 10;

    // Config port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_GRID_SIZE  = 2'd0;
    localparam logic [1:0] REG_DISL_COUNT = 2'd1;
    localparam logic [1:0] REG_LINE_MODE  = 2'd2;

    // Cell codes
    localparam logic [CELL_W-1:0] CELL_FREE   = 2'd0;
    localparam logic [CELL_W-1:0] CELL_MOBILE = 2'd1;
    localparam logic [CELL_W-1:0] CELL_PINNED = 2'd2;

    // Move directions
    localparam logic [DIR_W-1:0] DIR_XP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_XM = 2'd1;
    localparam logic [DIR_W-1:0] DIR_YM = 2'd2;
    localparam logic [DIR_W-1:0] DIR_YP = 2'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_PLACE = 2'd1,
        ACT_CHECK = 2'd2,
        ACT_MOVE  = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_PLACE,
        ST_MV_TAB,
        ST_MV_CELL,
        ST_MV_RD,
        ST_MV_CHK,
        ST_MV_TGT,
        ST_MV_GO,
        ST_CK_TAB,
        ST_CK_LOAD,
        ST_CK_RD,
        ST_CK_EVAL,
        ST_CK_NBRD,
        ST_CK_NBEV,
        ST_CK_PIN,
        ST_CK_FIN,
        ST_FINISH
    } state_t;

endpackage

// ===== sv/ldw_req_if.sv =====
interface ldw_req_if;
    import ldw_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  entry_index;
    logic [COORD8_W-1:0] place_x;
    logic [COORD8_W-1:0] place_y;
    logic [DIR_W-1:0]    direction;

    modport source (
        output valid, action, entry_index, place_x, place_y, direction,
        input  ready
    );

    modport sink (
        input  valid, action, entry_index, place_x, place_y, direction,
        output ready
    );
endinterface

// ===== sv/ldw_rsp_if.sv =====
interface ldw_rsp_if;
    import ldw_pkg::*;

    logic                valid;
    logic                ready;
    logic                any_mobile;
    logic [ROUND_W-1:0]  round_count;
    logic [COORD8_W-1:0] new_x;
    logic [COORD8_W-1:0] new_y;
    logic                entry_pinned;

    modport source (
        output valid, any_mobile, round_count, new_x, new_y, entry_pinned,
        input  ready
    );

    modport sink (
        input  valid, any_mobile, round_count, new_x, new_y, entry_pinned,
        output ready
    );
endinterface

// ===== sv/lattice_dislocation_walk_unit.sv =====
// Lattice dislocation walk: a grid of 2-bit cells (free, mobile, pinned) in a
// single-port-write, single-port-read RAM plus a position table RAM, driven by
// a small sequencer around one shared coordinate step/bounds unit. One beat is
// worked at a time and req.ready is low while it runs. A check walks the table
// entries in turn; cell reads of the four neighbors go one at a time through
// the cell RAM read port. A clear frees the n by n cells for grid side n in
// use. After reset the block sweeps all 2**(2*clog2(GRID_SIDE)) cells of the
// cell RAM once (65536 at the default size) before it takes its first beat;
// config writes are taken at any time. A finished result waits in the output
// register while the next beat is accepted. Table entries read before they
// are placed return undefined positions.
`include "assert_macros.svh"

module lattice_dislocation_walk_unit #(
    parameter int GRID_SIDE   = ldw_pkg::GRID_SIDE_DEF,
    parameter int MAX_ENTRIES = ldw_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ldw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ldw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ldw_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    ldw_req_if.sink                       req,
    ldw_rsp_if.source                     rsp
);
    import ldw_pkg::*;

    localparam int LW         = $clog2(GRID_SIDE);
    localparam int CELL_AW    = 2 * LW;
    localparam int CELL_DEPTH = 1 << CELL_AW;
    localparam int TW         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int TAB_W      = 2 * COORD8_W;
    localparam logic [16:0] MAXE     = 17'(MAX_ENTRIES);
    localparam logic [10:0] GSIDE_11 = 11'(GRID_SIDE);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [GSIZE_W-1:0] grid_size_reg;
    logic [CNT_W-1:0]   disl_count_reg;
    logic               line_mode_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg  <= 9'd256;
            disl_count_reg <= 11'd1;
            line_mode_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_GRID_SIZE:  grid_size_reg  <= pwdata[GSIZE_W-1:0];
                REG_DISL_COUNT: disl_count_reg <= pwdata[CNT_W-1:0];
                REG_LINE_MODE:  line_mode_reg  <= pwdata[0];
                default:        ;
            endcase
        end
    end

    // Return register contents
    always_comb
    begin
        unique case (paddr[3:2])
            REG_GRID_SIZE:  prdata = 32'(grid_size_reg);
            REG_DISL_COUNT: prdata = 32'(disl_count_reg);
            REG_LINE_MODE:  prdata = 32'(line_mode_reg);
            default:        prdata = '0;
        endcase
    end

    // Clamp side and count to what the storage holds
    logic [10:0]        gs_wide;
    logic [10:0]        n_wide;
    logic [GSIZE_W-1:0] n_eff;
    logic [COORD_W-1:0] n_m1;
    logic [16:0]        cnt_wide;
    logic [CNT_W-1:0]   cnt;

    assign gs_wide  = 11'(grid_size_reg);
    assign n_wide   = (gs_wide > GSIDE_11) ? GSIDE_11 : gs_wide;
    assign n_eff    = n_wide[GSIZE_W-1:0];
    assign n_m1     = 10'(n_eff) - 10'd1;
    assign cnt_wide = (17'(disl_count_reg) > MAXE) ? MAXE : 17'(disl_count_reg);
    assign cnt      = cnt_wide[CNT_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [LW-1:0]         i_reg, i_next;
    logic [LW-1:0]         j_reg, j_next;
    logic [CNT_W-1:0]      e_reg, e_next;
    logic [1:0]            nb_reg, nb_next;
    logic [COORD8_W-1:0]   x_reg, x_next;
    logic [COORD8_W-1:0]   y_reg, y_next;
    action_t               act_reg, act_next;
    logic [INDEX_W-1:0]    k_reg, k_next;
    logic [DIR_W-1:0]      dir_reg, dir_next;
    logic                  pin_reg, pin_next;
    logic                  own_mob_reg, own_mob_next;
    logic                  own_in_reg, own_in_next;
    logic                  tgt_in_reg, tgt_in_next;
    logic                  alive_flag_reg, alive_flag_next;
    logic [ROUND_W-1:0]    alive_rounds_reg, alive_rounds_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  o_any_reg, o_any_next;
    logic [ROUND_W-1:0]    o_round_reg, o_round_next;
    logic [COORD8_W-1:0]   o_x_reg, o_x_next;
    logic [COORD8_W-1:0]   o_y_reg, o_y_next;
    logic                  o_pin_reg, o_pin_next;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic [CELL_W-1:0]  cell_mem [CELL_DEPTH];
    logic [CELL_W-1:0]  cell_rd_reg;
    logic               cell_we;
    logic [CELL_AW-1:0] cell_waddr;
    logic [CELL_W-1:0]  cell_wdata;
    logic [CELL_AW-1:0] cell_raddr;

    logic [TAB_W-1:0]   tab_mem [MAX_ENTRIES];
    logic [TAB_W-1:0]   tab_rd_reg;
    logic               tab_we;
    logic [TW-1:0]      tab_waddr;
    logic [TAB_W-1:0]   tab_wdata;
    logic [TW-1:0]      tab_raddr;

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        cell_rd_reg <= cell_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        tab_rd_reg <= tab_mem[tab_raddr];
    end

    // ------------------------------------------------------------------
    // Shared coordinate unit: optional unit step, bounds check, cell address
    // ------------------------------------------------------------------
    logic                      cu_step;
    logic [DIR_W-1:0]          cu_dir;
    logic signed [COORD_W-1:0] cu_bx, cu_by, cu_x, cu_y, cu_n;
    logic                      cu_in;
    logic [CELL_AW-1:0]        cu_addr;

    assign cu_bx = signed'({2'b00, x_reg});
    assign cu_by = signed'({2'b00, y_reg});
    assign cu_n  = signed'({1'b0, n_eff});

    always_comb
    begin
        cu_x = cu_bx;
        cu_y = cu_by;
        if (cu_step)
        begin
            unique case (cu_dir)
                DIR_XP: cu_x = cu_bx + 10'sd1;
                DIR_XM: cu_x = cu_bx - 10'sd1;
                DIR_YM: cu_y = cu_by - 10'sd1;
                DIR_YP: cu_y = cu_by + 10'sd1;
                default: ;
            endcase
        end
        cu_in   = (cu_x >= 10'sd0) && (cu_y >= 10'sd0) && (cu_x < cu_n) && (cu_y < cu_n);
        cu_addr = {cu_x[LW-1:0], cu_y[LW-1:0]};
    end

    // ------------------------------------------------------------------
    // Derived conditions
    // ------------------------------------------------------------------
    logic             accept;
    logic             take_clear;
    logic             k_in_tab;
    logic             k_in_cnt;
    logic [DIR_W-1:0] mv_dir;
    logic             on_edge;
    logic             out_free;
    logic [TAB_W-1:0] step_pos;
    logic             nb_state;

    assign req.ready  = (state_reg == ST_IDLE);
    assign accept     = req.valid & req.ready;
    assign take_clear = accept && (req.action == ACT_CLEAR);
    assign k_in_tab   = 17'(k_reg) < MAXE;
    assign k_in_cnt   = 11'(k_reg) < cnt;
    assign mv_dir     = line_mode_reg ? {1'b0, dir_reg[0]} : dir_reg;
    assign on_edge    = (x_reg == '0) || (10'(x_reg) == n_m1) ||
                        (!line_mode_reg && ((y_reg == '0) || (10'(y_reg) == n_m1)));
    assign out_free   = !out_valid_reg || rsp.ready;
    assign step_pos   = {cu_x[COORD8_W-1:0], cu_y[COORD8_W-1:0]};

    // Step the coordinate unit by state only: target cell or a neighbor
    assign nb_state = (state_reg == ST_CK_NBRD) || (state_reg == ST_CK_NBEV);
    assign cu_step  = nb_state || (state_reg == ST_MV_CHK) || (state_reg == ST_MV_GO);
    assign cu_dir   = nb_state ? nb_reg : mv_dir;

    // ------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        e_next            = e_reg;
        nb_next           = nb_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        act_next          = act_reg;
        k_next            = k_reg;
        dir_next          = dir_reg;
        pin_next          = pin_reg;
        own_mob_next      = own_mob_reg;
        own_in_next       = own_in_reg;
        tgt_in_next       = tgt_in_reg;
        alive_flag_next   = alive_flag_reg;
        alive_rounds_next = alive_rounds_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        o_any_next        = o_any_reg;
        o_round_next      = o_round_reg;
        o_x_next          = o_x_reg;
        o_y_next          = o_y_reg;
        o_pin_next        = o_pin_reg;

        cell_we    = 1'b0;
        cell_waddr = cu_addr;
        cell_wdata = CELL_FREE;
        cell_raddr = cu_addr;
        tab_we     = 1'b0;
        tab_waddr  = TW'(k_reg);
        tab_wdata  = step_pos;
        tab_raddr  = TW'(k_reg);

        unique case (state_reg)
            // Sweep the whole cell RAM after reset
            ST_INIT:
            begin
                cell_we    = 1'b1;
                cell_waddr = {i_reg, j_reg};
                j_next     = j_reg + 1'b1;
                if (&j_reg)
                begin
                    i_next = i_reg + 1'b1;
                    if (&i_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // Take a beat and latch its fields
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next = action_t'(req.action);
                    k_next   = req.entry_index;
                    dir_next = req.direction;
                    x_next   = req.place_x;
                    y_next   = req.place_y;
                    pin_next = 1'b0;
                    i_next   = '0;
                    j_next   = '0;
                    unique case (action_t'(req.action))
                        ACT_CLEAR:
                        begin
                            alive_rounds_next = '0;
                            state_next = (n_eff == '0) ? ST_FINISH : ST_CLEAR;
                        end
                        ACT_PLACE:
                        begin
                            state_next = ST_PLACE;
                        end
                        ACT_CHECK:
                        begin
                            e_next          = '0;
                            alive_flag_next = 1'b0;
                            state_next      = ST_CK_TAB;
                        end
                        ACT_MOVE:
                        begin
                            state_next = ST_MV_TAB;
                        end
                        default: ;
                    endcase
                end
            end

            // Free the n by n grid, one cell a cycle
            ST_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = {i_reg, j_reg};
                if (10'(j_reg) == n_m1)
                begin
                    j_next = '0;
                    if (10'(i_reg) == n_m1)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end

            // Record position and mark the cell mobile
            ST_PLACE:
            begin
                if (k_in_tab)
                begin
                    tab_we     = 1'b1;
                    tab_wdata  = {x_reg, y_reg};
                    cell_we    = cu_in;
                    cell_wdata = CELL_MOBILE;
                end
                state_next = ST_FINISH;
            end

            // Move: fetch the entry position
            ST_MV_TAB:
            begin
                state_next = k_in_tab ? ST_MV_CELL : ST_FINISH;
            end

            ST_MV_CELL:
            begin
                x_next     = tab_rd_reg[TAB_W-1:COORD8_W];
                y_next     = tab_rd_reg[COORD8_W-1:0];
                state_next = k_in_cnt ? ST_MV_RD : ST_FINISH;
            end

            // Read own cell and hold its bounds flag
            ST_MV_RD:
            begin
                own_in_next = cu_in;
                state_next  = ST_MV_CHK;
            end

            // Stop if pinned, else read the target cell and hold its bounds flag
            ST_MV_CHK:
            begin
                tgt_in_next = cu_in;
                if (own_in_reg && (cell_rd_reg == CELL_PINNED))
                begin
                    pin_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MV_TGT;
                end
            end

            // Free own cell on a step, else mark it mobile again
            ST_MV_TGT:
            begin
                cell_we = cu_in;
                if (tgt_in_reg && (cell_rd_reg == CELL_FREE))
                begin
                    cell_wdata = CELL_FREE;
                    state_next = ST_MV_GO;
                end
                else
                begin
                    cell_wdata = CELL_MOBILE;
                    state_next = ST_FINISH;
                end
            end

            // Occupy the target and update the table
            ST_MV_GO:
            begin
                cell_we    = 1'b1;
                cell_wdata = CELL_MOBILE;
                tab_we     = 1'b1;
                x_next     = cu_x[COORD8_W-1:0];
                y_next     = cu_y[COORD8_W-1:0];
                state_next = ST_FINISH;
            end

            // Check: next entry or done
            ST_CK_TAB:
            begin
                tab_raddr  = TW'(e_reg);
                state_next = (e_reg < cnt) ? ST_CK_LOAD : ST_CK_FIN;
            end

            ST_CK_LOAD:
            begin
                x_next     = tab_rd_reg[TAB_W-1:COORD8_W];
                y_next     = tab_rd_reg[COORD8_W-1:0];
                state_next = ST_CK_RD;
            end

            ST_CK_RD:
            begin
                state_next = ST_CK_EVAL;
            end

            // Skip pinned or off-grid entries, pin on an edge
            ST_CK_EVAL:
            begin
                own_mob_next = (cell_rd_reg == CELL_MOBILE);
                nb_next      = '0;
                if (!cu_in || (cell_rd_reg == CELL_PINNED))
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_CK_TAB;
                end
                else if (on_edge)
                begin
                    state_next = ST_CK_PIN;
                end
                else
                begin
                    state_next = ST_CK_NBRD;
                end
            end

            // Read one neighbor
            ST_CK_NBRD:
            begin
                state_next = ST_CK_NBEV;
            end

            // Pin on an occupied neighbor, else try the next one
            ST_CK_NBEV:
            begin
                if (cu_in && (cell_rd_reg != CELL_FREE))
                begin
                    state_next = ST_CK_PIN;
                end
                else if (nb_reg == 2'd3)
                begin
                    alive_flag_next = alive_flag_reg | own_mob_reg;
                    e_next          = e_reg + 1'b1;
                    state_next      = ST_CK_TAB;
                end
                else
                begin
                    nb_next    = nb_reg + 1'b1;
                    state_next = ST_CK_NBRD;
                end
            end

            ST_CK_PIN:
            begin
                cell_we    = 1'b1;
                cell_wdata = CELL_PINNED;
                e_next     = e_reg + 1'b1;
                state_next = ST_CK_TAB;
            end

            // Count an alive pass, saturating
            ST_CK_FIN:
            begin
                if (alive_flag_reg && !(&alive_rounds_reg))
                begin
                    alive_rounds_next = alive_rounds_reg + 1'b1;
                end
                state_next = ST_FINISH;
            end

            // Load the result register once it is free
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_any_next     = 1'b0;
                    o_round_next   = '0;
                    o_x_next       = '0;
                    o_y_next       = '0;
                    o_pin_next     = 1'b0;
                    unique case (act_reg)
                        ACT_CLEAR: ;
                        ACT_PLACE, ACT_MOVE:
                        begin
                            if (k_in_tab)
                            begin
                                o_x_next = x_reg;
                                o_y_next = y_reg;
                            end
                            o_pin_next = pin_reg;
                        end
                        ACT_CHECK:
                        begin
                            o_any_next   = alive_flag_reg;
                            o_round_next = alive_rounds_reg;
                        end
                        default: ;
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State register and control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg            <= '0;
            j_reg            <= '0;
            e_reg            <= '0;
            nb_reg           <= '0;
            act_reg          <= ACT_CLEAR;
            pin_reg          <= 1'b0;
            own_mob_reg      <= 1'b0;
            own_in_reg       <= 1'b0;
            tgt_in_reg       <= 1'b0;
            alive_flag_reg   <= 1'b0;
            alive_rounds_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            i_reg            <= i_next;
            j_reg            <= j_next;
            e_reg            <= e_next;
            nb_reg           <= nb_next;
            act_reg          <= act_next;
            pin_reg          <= pin_next;
            own_mob_reg      <= own_mob_next;
            own_in_reg       <= own_in_next;
            tgt_in_reg       <= tgt_in_next;
            alive_flag_reg   <= alive_flag_next;
            alive_rounds_reg <= alive_rounds_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        k_reg       <= k_next;
        dir_reg     <= dir_next;
        o_any_reg   <= o_any_next;
        o_round_reg <= o_round_next;
        o_x_reg     <= o_x_next;
        o_y_reg     <= o_y_next;
        o_pin_reg   <= o_pin_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.any_mobile   = o_any_reg;
    assign rsp.round_count  = o_round_reg;
    assign rsp.new_x        = o_x_reg;
    assign rsp.new_y        = o_y_reg;
    assign rsp.entry_pinned = o_pin_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_idle_no_cell_write, state_reg == ST_IDLE, !cell_we)
    `ASSERT_IMPL(a_pin_writes_pinned, state_reg == ST_CK_PIN, cell_we && (cell_wdata == CELL_PINNED))
    `ASSERT_IMPL(a_clear_in_grid, state_reg == ST_CLEAR, (10'(i_reg) <= n_m1) && (10'(j_reg) <= n_m1))
    `ASSERT_IMPL(a_rsp_from_finish, $rose(rsp.valid), $past(state_reg) == ST_FINISH)
    `ASSERT_NEXT(a_rounds_hold, (state_reg != ST_CK_FIN) && !take_clear, $stable(alive_rounds_reg))

endmodule
